// File: design/stl_pkg.sv
`default_nettype none
package stl_pkg;

  localparam int MaxLine = 1024;
  localparam int KeywordChars = 7;
  localparam int NumKeywords = 18;
  localparam logic [9:0] LenMax = 10'd1023;
  localparam logic [9:0] ColMax = (MaxLine - 1 < 1023) ? 10'(MaxLine - 1) : 10'd1023;

  localparam logic [5:0] KSym0   = 6'd18;
  localparam logic [5:0] KIdent  = 6'd46;
  localparam logic [5:0] KInt    = 6'd47;
  localparam logic [5:0] KFloat  = 6'd48;
  localparam logic [5:0] KString = 6'd49;
  localparam logic [5:0] KSchar  = 6'd50;
  localparam logic [5:0] KEnd    = 6'd51;
  localparam logic [5:0] KError  = 6'd52;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrEscape    = 3'd1;
  localparam logic [2:0] ErrPoint     = 3'd2;
  localparam logic [2:0] ErrUnknown   = 3'd3;
  localparam logic [2:0] ErrUntermin  = 3'd4;

  localparam logic [5:0] NoSym = 6'd63;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_PEND, M_STRING, M_ESCAPE, M_SKIP
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [9:0]  start_column;
    logic [9:0]  token_length;
    logic [63:0] int_value;
    logic [63:0] fraction_value;
    logic [9:0]  fraction_digits;
    logic [7:0]  char_value;
    logic [2:0]  error_code;
    logic        is_last;
  } out_item_t;

  function automatic logic [5:0] single_symbol(input logic [7:0] c);
    logic [5:0] k;
    k = NoSym;
    case (c)
      8'h28: k = KSym0 + 6'd6;
      8'h29: k = KSym0 + 6'd7;
      8'h5B: k = KSym0 + 6'd8;
      8'h5D: k = KSym0 + 6'd9;
      8'h7B: k = KSym0 + 6'd10;
      8'h7D: k = KSym0 + 6'd11;
      8'h2C: k = KSym0 + 6'd12;
      8'h3A: k = KSym0 + 6'd13;
      8'h3B: k = KSym0 + 6'd14;
      8'h2E: k = KSym0 + 6'd15;
      8'h3D: k = KSym0 + 6'd16;
      8'h2B: k = KSym0 + 6'd17;
      8'h2D: k = KSym0 + 6'd18;
      8'h2A: k = KSym0 + 6'd19;
      8'h2F: k = KSym0 + 6'd20;
      8'h25: k = KSym0 + 6'd21;
      8'h26: k = KSym0 + 6'd22;
      8'h7C: k = KSym0 + 6'd23;
      8'h5E: k = KSym0 + 6'd24;
      8'h21: k = KSym0 + 6'd25;
      8'h3C: k = KSym0 + 6'd26;
      8'h3E: k = KSym0 + 6'd27;
      default: k = NoSym;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_symbol(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = NoSym;
    if (a == 8'h26 && b == 8'h26) k = KSym0;
    else if (a == 8'h7C && b == 8'h7C) k = KSym0 + 6'd1;
    else if (a == 8'h3C && b == 8'h3D) k = KSym0 + 6'd2;
    else if (a == 8'h3E && b == 8'h3D) k = KSym0 + 6'd3;
    else if (a == 8'h3D && b == 8'h3D) k = KSym0 + 6'd4;
    else if (a == 8'h21 && b == 8'h3D) k = KSym0 + 6'd5;
    return k;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic starts_pair(input logic [7:0] c);
    return c == 8'h26 || c == 8'h7C || c == 8'h3C || c == 8'h3E || c == 8'h3D || c == 8'h21;
  endfunction

  function automatic logic [5:0] keyword_kind(input logic [55:0] w, input logic [9:0] n);
    logic [5:0] k;
    k = KIdent;
    case (n)
      10'd2: begin
        if (w[15:0] == "if") k = 6'd0;
        else if (w[15:0] == "in") k = 6'd6;
      end
      10'd3: begin
        if (w[23:0] == "for") k = 6'd5;
        else if (w[23:0] == "int") k = 6'd10;
        else if (w[23:0] == "any") k = 6'd16;
        else if (w[23:0] == "nil") k = 6'd17;
      end
      10'd4: begin
        if (w[31:0] == "elif") k = 6'd1;
        else if (w[31:0] == "else") k = 6'd2;
        else if (w[31:0] == "func") k = 6'd9;
        else if (w[31:0] == "bool") k = 6'd13;
        else if (w[31:0] == "list") k = 6'd14;
        else if (w[31:0] == "dict") k = 6'd15;
      end
      10'd5: begin
        if (w[39:0] == "while") k = 6'd3;
        else if (w[39:0] == "float") k = 6'd11;
      end
      10'd6: begin
        if (w[47:0] == "return") k = 6'd7;
        else if (w[47:0] == "istype") k = 6'd8;
        else if (w[47:0] == "string") k = 6'd12;
      end
      10'd7: begin
        if (w[55:0] == "foreach") k = 6'd4;
      end
      default: k = KIdent;
    endcase
    return k;
  endfunction

  function automatic logic [9:0] sat_inc(input logic [9:0] v);
    return (v < LenMax) ? v + 10'd1 : v;
  endfunction

endpackage
`default_nettype wire

// File: design/source_token_lexer.sv
// source_token_lexer: streaming tokenizer, one source byte per input beat.
// Input channel in_valid/in_ready carries in_data (byte, end_of_input flag).
// Output channel out_valid/out_ready carries out_data, one token per beat.
// Each input beat yields zero, one or two tokens; is_last marks the final
// token of a beat. Tokens are registered in the result buffer before output.
// Throughput is one byte per cycle while out_ready stays high; a byte that yields
// two tokens holds the input while the second token drains from the
// two-entry result buffer, which is the only limit on rate.
// Reset clears the lexer state and the column and empties the result buffer.
// When the receiver stalls, tokens stay in the buffer and in_ready drops
// once the buffer cannot hold the results of another byte; nothing is lost.
`default_nettype none
module source_token_lexer import stl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  lex_mode_t   lex_mode, lex_mode_next;
  logic [9:0]  column_count, column_count_next;
  logic [9:0]  token_start, token_start_next;
  logic [9:0]  token_count, token_count_next;
  logic [55:0] keyword_window, keyword_window_next;
  logic [63:0] integer_accum, integer_accum_next;
  logic [63:0] fraction_accum, fraction_accum_next;
  logic [9:0]  fraction_count, fraction_count_next;
  logic        seen_point, seen_point_next;
  logic        quote_is_double, quote_is_double_next;
  logic [7:0]  pending_symbol, pending_symbol_next;

  out_item_t   slot [2];
  logic [1:0]  fill;
  out_item_t   res [2];
  logic [1:0]  nres;

  logic        take, give;
  logic [7:0]  c;

  assign c = in_data.in_byte;
  assign take = in_valid && in_ready;
  assign out_valid = fill != 2'd0;
  assign give = out_valid && out_ready;
  assign out_data = slot[0];
  assign in_ready = (fill == 2'd0) || (fill == 2'd1 && out_ready);

  function automatic out_item_t mk(input logic [5:0] k, input logic [9:0] s,
                                   input logic [9:0] l, input logic [63:0] iv,
                                   input logic [63:0] fv, input logic [9:0] fd,
                                   input logic [7:0] ch, input logic [2:0] e);
    out_item_t r;
    r.token_kind = k;
    r.start_column = s;
    r.token_length = l;
    r.int_value = iv;
    r.fraction_value = fv;
    r.fraction_digits = fd;
    r.char_value = ch;
    r.error_code = e;
    r.is_last = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [5:0]  k;
    logic [9:0]  elen;
    logic [63:0] ten_int, ten_frac;
    logic        restart;
    lex_mode_next = lex_mode;
    column_count_next = column_count;
    token_start_next = token_start;
    token_count_next = token_count;
    keyword_window_next = keyword_window;
    integer_accum_next = integer_accum;
    fraction_accum_next = fraction_accum;
    fraction_count_next = fraction_count;
    seen_point_next = seen_point;
    quote_is_double_next = quote_is_double;
    pending_symbol_next = pending_symbol;
    res[0] = '0;
    res[1] = '0;
    nres = 2'd0;
    restart = 1'b0;
    k = '0;
    elen = (column_count >= token_start) ? column_count - token_start : 10'd0;
    ten_int = (integer_accum << 3) + (integer_accum << 1) + 64'(c - 8'h30);
    ten_frac = (fraction_accum << 3) + (fraction_accum << 1) + 64'(c - 8'h30);

    if (in_data.end_of_input || c == 8'h0A) begin
      case (lex_mode)
        M_IDENT: begin
          res[0] = mk(keyword_kind(keyword_window, token_count), token_start,
                      token_count, '0, '0, '0, '0, ErrNone);
          nres = 2'd1;
        end
        M_NUMBER: begin
          res[0] = seen_point ?
            mk(KFloat, token_start, token_count, integer_accum, fraction_accum,
               fraction_count, '0, ErrNone) :
            mk(KInt, token_start, token_count, integer_accum, '0, '0, '0, ErrNone);
          nres = 2'd1;
        end
        M_PEND: begin
          k = single_symbol(pending_symbol);
          res[0] = (k == NoSym) ?
            mk(KError, token_start, 10'd1, '0, '0, '0, '0, ErrUnknown) :
            mk(k, token_start, 10'd1, '0, '0, '0, '0, ErrNone);
          nres = 2'd1;
        end
        M_STRING: begin
          res[0] = mk(KError, token_start, elen, '0, '0, '0, '0, ErrUntermin);
          nres = 2'd1;
        end
        M_ESCAPE: begin
          res[0] = mk(KError, token_start, elen, '0, '0, '0, '0, ErrEscape);
          nres = 2'd1;
        end
        default: nres = 2'd0;
      endcase
      lex_mode_next = M_IDLE;
      if (in_data.end_of_input) begin
        res[nres[0]] = mk(KEnd, column_count, '0, '0, '0, '0, '0, ErrNone);
        nres = nres + 2'd1;
      end else begin
        column_count_next = '0;
      end
    end else begin
      if (column_count < ColMax) column_count_next = column_count + 10'd1;
      case (lex_mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            token_count_next = sat_inc(token_count);
            keyword_window_next = {keyword_window[47:0], c};
          end else begin
            res[0] = mk(keyword_kind(keyword_window, token_count), token_start,
                        token_count, '0, '0, '0, '0, ErrNone);
            nres = 2'd1;
            restart = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            if (seen_point) begin
              fraction_accum_next = ten_frac;
              fraction_count_next = sat_inc(fraction_count);
            end else begin
              integer_accum_next = ten_int;
            end
            token_count_next = sat_inc(token_count);
          end else if (c == 8'h2E) begin
            if (!seen_point) begin
              seen_point_next = 1'b1;
              token_count_next = sat_inc(token_count);
            end else begin
              res[0] = mk(KError, token_start, (elen == LenMax) ? LenMax : elen + 10'd1,
                          '0, '0, '0, '0, ErrPoint);
              nres = 2'd1;
              lex_mode_next = M_SKIP;
            end
          end else begin
            res[0] = seen_point ?
              mk(KFloat, token_start, token_count, integer_accum, fraction_accum,
                 fraction_count, '0, ErrNone) :
              mk(KInt, token_start, token_count, integer_accum, '0, '0, '0, ErrNone);
            nres = 2'd1;
            restart = 1'b1;
          end
        end
        M_PEND: begin
          k = pair_symbol(pending_symbol, c);
          lex_mode_next = M_IDLE;
          if (k != NoSym) begin
            res[0] = mk(k, token_start, 10'd2, '0, '0, '0, '0, ErrNone);
            nres = 2'd1;
          end else begin
            k = single_symbol(pending_symbol);
            res[0] = (k == NoSym) ?
              mk(KError, token_start, 10'd1, '0, '0, '0, '0, ErrUnknown) :
              mk(k, token_start, 10'd1, '0, '0, '0, '0, ErrNone);
            nres = 2'd1;
            restart = 1'b1;
          end
        end
        M_STRING: begin
          if (c == (quote_is_double ? 8'h22 : 8'h27)) begin
            res[0] = mk(KString, token_start, token_count, '0, '0, '0, '0, ErrNone);
            nres = 2'd1;
            lex_mode_next = M_IDLE;
          end else if (c == 8'h5C) begin
            lex_mode_next = M_ESCAPE;
          end else begin
            res[0] = mk(KSchar, token_start, '0, '0, '0, '0, c, ErrNone);
            nres = 2'd1;
            token_count_next = sat_inc(token_count);
          end
        end
        M_ESCAPE: begin
          lex_mode_next = M_STRING;
          token_count_next = sat_inc(token_count);
          nres = 2'd1;
          case (c)
            8'h6E: res[0] = mk(KSchar, token_start, '0, '0, '0, '0, 8'h0A, ErrNone);
            8'h74: res[0] = mk(KSchar, token_start, '0, '0, '0, '0, 8'h09, ErrNone);
            8'h5C, 8'h22, 8'h27:
              res[0] = mk(KSchar, token_start, '0, '0, '0, '0, c, ErrNone);
            8'h30: res[0] = mk(KSchar, token_start, '0, '0, '0, '0, 8'h00, ErrNone);
            default: begin
              res[0] = mk(KError, token_start, (elen == LenMax) ? LenMax : elen + 10'd1,
                          '0, '0, '0, '0, ErrEscape);
              lex_mode_next = M_SKIP;
              token_count_next = token_count;
            end
          endcase
        end
        M_SKIP: lex_mode_next = M_SKIP;
        default: restart = 1'b1;
      endcase

      if (restart) begin
        lex_mode_next = M_IDLE;
        token_start_next = column_count;
        if (c == 8'h20 || c == 8'h09) begin
          lex_mode_next = M_IDLE;
        end else if (is_alpha(c)) begin
          lex_mode_next = M_IDENT;
          token_count_next = 10'd1;
          keyword_window_next = {48'd0, c};
        end else if (is_digit(c)) begin
          lex_mode_next = M_NUMBER;
          token_count_next = 10'd1;
          integer_accum_next = 64'(c - 8'h30);
          fraction_accum_next = '0;
          fraction_count_next = '0;
          seen_point_next = 1'b0;
        end else if (c == 8'h22 || c == 8'h27) begin
          lex_mode_next = M_STRING;
          quote_is_double_next = c == 8'h22;
          token_count_next = '0;
        end else if (c == 8'h23) begin
          lex_mode_next = M_SKIP;
        end else if (starts_pair(c)) begin
          lex_mode_next = M_PEND;
          pending_symbol_next = c;
        end else begin
          k = single_symbol(c);
          if (k != NoSym) begin
            res[nres[0]] = mk(k, column_count, 10'd1, '0, '0, '0, '0, ErrNone);
          end else begin
            res[nres[0]] = mk(KError, column_count, 10'd1, '0, '0, '0, '0, ErrUnknown);
            lex_mode_next = M_SKIP;
          end
          nres = nres + 2'd1;
        end
      end
    end
    if (nres == 2'd1) res[0].is_last = 1'b1;
    if (nres == 2'd2) res[1].is_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= M_IDLE;
      column_count <= '0;
      token_start <= '0;
      token_count <= '0;
      keyword_window <= '0;
      integer_accum <= '0;
      fraction_accum <= '0;
      fraction_count <= '0;
      seen_point <= 1'b0;
      quote_is_double <= 1'b0;
      pending_symbol <= '0;
    end else if (take) begin
      lex_mode <= lex_mode_next;
      column_count <= column_count_next;
      token_start <= token_start_next;
      token_count <= token_count_next;
      keyword_window <= keyword_window_next;
      integer_accum <= integer_accum_next;
      fraction_accum <= fraction_accum_next;
      fraction_count <= fraction_count_next;
      seen_point <= seen_point_next;
      quote_is_double <= quote_is_double_next;
      pending_symbol <= pending_symbol_next;
    end
  end

  always_ff @(posedge clk) begin
    logic [1:0] base;
    base = fill - {1'b0, give};
    if (rst) begin
      fill <= '0;
    end else begin
      if (give) slot[0] <= slot[1];
      if (take && nres != 2'd0) begin
        if (base == 2'd0) begin
          slot[0] <= res[0];
          slot[1] <= res[1];
        end else begin
          slot[1] <= res[0];
        end
      end
      fill <= base + (take ? nres : 2'd0);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("result buffer overfilled");
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !in_ready)
    else $error("input taken with full buffer");
  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (take && lex_mode == M_SKIP && !in_data.end_of_input) |=> (fill <= $past(fill)))
    else $error("skipped byte produced a token");

endmodule
`default_nettype wire

// File: tb/sv/tb_source_token_lexer.sv
`timescale 1ns / 1ps
module tb_source_token_lexer;
  import stl_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  source_token_lexer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  in_item_t  byte_q[$];
  out_item_t token_q[$];
  out_item_t step_q[$];
  int        send_idle;
  int        recv_idle;
  int        errors;
  int        hold_cnt;
  int        cyc;

  string kw_names[NumKeywords] = '{"if", "elif", "else", "while", "foreach", "for", "in",
    "return", "istype", "func", "int", "float", "string", "bool", "list", "dict",
    "any", "nil"};
  string one_syms = "()[]{},:;.=+-*/%&|^!<>";
  string two_syms = "&&||<=>===!=";
  string esc_chars = "nt\\\"'0";

  lex_mode_t   mode;
  logic [9:0]  col;
  logic [9:0]  tstart;
  logic [9:0]  tcount;
  logic [55:0] kwin;
  logic [63:0] iacc;
  logic [63:0] facc;
  logic [9:0]  fcnt;
  logic        seen_pt;
  logic        dquote;
  logic [7:0]  pend_sym;

  function automatic logic [9:0] bump(logic [9:0] v);
    return (v < LenMax) ? v + 10'd1 : v;
  endfunction

  function automatic logic [5:0] one_sym(logic [7:0] c);
    for (int i = 0; i < one_syms.len(); i++)
      if (one_syms[i] == c) return KSym0 + 6'(6 + i);
    return NoSym;
  endfunction

  function automatic logic [5:0] two_sym(logic [7:0] a, logic [7:0] b);
    for (int i = 0; i < 6; i++)
      if (two_syms[2*i] == a && two_syms[2*i+1] == b) return KSym0 + 6'(i);
    return NoSym;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] word_kind(logic [55:0] w, logic [9:0] n);
    logic [55:0] v;
    logic [55:0] m;
    m = (56'd1 << (8 * n)) - 56'd1;
    for (int i = 0; i < NumKeywords; i++) begin
      if (kw_names[i].len() == int'(n)) begin
        v = '0;
        for (int j = 0; j < kw_names[i].len(); j++) v = {v[47:0], kw_names[i][j]};
        if ((w & m) == v) return 6'(i);
      end
    end
    return KIdent;
  endfunction

  task automatic emit(logic [5:0] kind, logic [9:0] start, int len, logic [63:0] iv,
                      logic [63:0] fv, int fd, logic [7:0] ch, logic [2:0] err);
    out_item_t r;
    r.token_kind = kind;
    r.start_column = start;
    r.token_length = (len > 1023) ? 10'd1023 : 10'(len);
    r.int_value = iv;
    r.fraction_value = fv;
    r.fraction_digits = (fd > 1023) ? 10'd1023 : 10'(fd);
    r.char_value = ch;
    r.error_code = err;
    r.is_last = 1'b0;
    step_q.insert(step_q.size(), r);
  endtask

  task automatic emit_err(logic [2:0] code, int extra);
    int len;
    len = (col >= tstart) ? int'(col) - int'(tstart) : 0;
    emit(KError, tstart, len + extra, '0, '0, 0, '0, code);
  endtask

  task automatic emit_word();
    emit((tcount <= 10'(KeywordChars)) ? word_kind(kwin, tcount) : KIdent, tstart,
         int'(tcount), '0, '0, 0, '0, ErrNone);
  endtask

  task automatic emit_num();
    if (seen_pt) emit(KFloat, tstart, int'(tcount), iacc, facc, int'(fcnt), '0, ErrNone);
    else emit(KInt, tstart, int'(tcount), iacc, '0, 0, '0, ErrNone);
  endtask

  task automatic emit_pend();
    logic [5:0] k;
    k = one_sym(pend_sym);
    if (k == NoSym) emit(KError, tstart, 1, '0, '0, 0, '0, ErrUnknown);
    else emit(k, tstart, 1, '0, '0, 0, '0, ErrNone);
  endtask

  task automatic flush_open();
    case (mode)
      M_IDENT: emit_word();
      M_NUMBER: emit_num();
      M_PEND: emit_pend();
      M_STRING: emit_err(ErrUntermin, 0);
      M_ESCAPE: emit_err(ErrEscape, 0);
      default: ;
    endcase
    mode = M_IDLE;
  endtask

  task automatic open_token(logic [7:0] c);
    logic [5:0] k;
    tstart = col;
    if (c == " " || c == "\t") return;
    if (is_letter(c)) begin
      mode = M_IDENT;
      tcount = 10'd1;
      kwin = {48'd0, c};
    end else if (is_num(c)) begin
      mode = M_NUMBER;
      tcount = 10'd1;
      iacc = 64'(c - "0");
      facc = '0;
      fcnt = '0;
      seen_pt = 1'b0;
    end else if (c == "\"" || c == "'") begin
      mode = M_STRING;
      dquote = (c == "\"");
      tcount = '0;
    end else if (c == "#") begin
      mode = M_SKIP;
    end else if (c == "&" || c == "|" || c == "<" || c == ">" || c == "=" || c == "!") begin
      mode = M_PEND;
      pend_sym = c;
    end else begin
      k = one_sym(c);
      if (k != NoSym) begin
        emit(k, col, 1, '0, '0, 0, '0, ErrNone);
      end else begin
        emit(KError, col, 1, '0, '0, 0, '0, ErrUnknown);
        mode = M_SKIP;
      end
    end
  endtask

  task automatic lex_char(logic [7:0] c);
    logic [5:0] k;
    logic [8:0] ch;
    case (mode)
      M_IDENT: begin
        if (is_letter(c) || is_num(c)) begin
          tcount = bump(tcount);
          kwin = {kwin[47:0], c};
        end else begin
          emit_word();
          mode = M_IDLE;
          open_token(c);
        end
      end
      M_NUMBER: begin
        if (is_num(c)) begin
          if (seen_pt) begin
            facc = facc * 64'd10 + 64'(c - "0");
            fcnt = bump(fcnt);
          end else begin
            iacc = iacc * 64'd10 + 64'(c - "0");
          end
          tcount = bump(tcount);
        end else if (c == ".") begin
          if (!seen_pt) begin
            seen_pt = 1'b1;
            tcount = bump(tcount);
          end else begin
            emit_err(ErrPoint, 1);
            mode = M_SKIP;
          end
        end else begin
          emit_num();
          mode = M_IDLE;
          open_token(c);
        end
      end
      M_PEND: begin
        k = two_sym(pend_sym, c);
        mode = M_IDLE;
        if (k != NoSym) begin
          emit(k, tstart, 2, '0, '0, 0, '0, ErrNone);
        end else begin
          emit_pend();
          open_token(c);
        end
      end
      M_STRING: begin
        if (c == (dquote ? "\"" : "'")) begin
          emit(KString, tstart, int'(tcount), '0, '0, 0, '0, ErrNone);
          mode = M_IDLE;
        end else if (c == "\\") begin
          mode = M_ESCAPE;
        end else begin
          emit(KSchar, tstart, 0, '0, '0, 0, c, ErrNone);
          tcount = bump(tcount);
        end
      end
      M_ESCAPE: begin
        case (c)
          "n": ch = 9'd10;
          "t": ch = 9'd9;
          "\\": ch = 9'h5C;
          "\"": ch = 9'h22;
          "'": ch = 9'h27;
          "0": ch = 9'd0;
          default: ch = 9'h100;
        endcase
        if (ch[8]) begin
          emit_err(ErrEscape, 1);
          mode = M_SKIP;
        end else begin
          emit(KSchar, tstart, 0, '0, '0, 0, ch[7:0], ErrNone);
          tcount = bump(tcount);
          mode = M_STRING;
        end
      end
      M_SKIP: ;
      default: begin
        mode = M_IDLE;
        open_token(c);
      end
    endcase
  endtask

  task automatic predict_tokens(in_item_t it);
    step_q.delete();
    if (it.end_of_input) begin
      flush_open();
      emit(KEnd, col, 0, '0, '0, 0, '0, ErrNone);
    end else if (it.in_byte == 8'd10) begin
      flush_open();
      col = '0;
    end else begin
      lex_char(it.in_byte);
      if (col < ColMax) col = col + 10'd1;
    end
    if (step_q.size() > 0) step_q[$].is_last = 1'b1;
    foreach (step_q[i]) token_q.insert(token_q.size(), step_q[i]);
  endtask

  task automatic put_ch(logic [7:0] c);
    byte_q.insert(byte_q.size(), '{in_byte: c, end_of_input: 1'b0});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  task automatic put_eoi();
    byte_q.insert(byte_q.size(), '{in_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
  endtask

  task automatic put_digits(int n);
    repeat (n) put_ch(8'("0" + $urandom_range(9)));
  endtask

  task automatic put_line();
    string pool;
    int    n;
    int    p;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    n = $urandom_range(1, 8);
    for (int t = 0; t < n; t++) begin
      case ($urandom_range(0, 11))
        0, 1: put_text(kw_names[$urandom_range(NumKeywords - 1)]);
        2: begin
          put_ch(pool[$urandom_range(52)]);
          repeat ($urandom_range(0, 9)) put_ch(pool[$urandom_range(62)]);
        end
        3: put_digits($urandom_range(1, 25));
        4: begin
          put_digits($urandom_range(1, 4));
          put_ch(".");
          put_digits($urandom_range(0, 22));
          if ($urandom_range(5) == 0) begin
            put_ch(".");
            put_digits($urandom_range(0, 3));
          end
        end
        5: put_ch(one_syms[$urandom_range(one_syms.len() - 1)]);
        6: begin
          p = 2 * $urandom_range(5);
          put_ch(two_syms[p]);
          if ($urandom_range(3) != 0) put_ch(two_syms[p + 1]);
        end
        7, 8: begin
          logic [7:0] q;
          q = $urandom_range(1) ? "\"" : "'";
          put_ch(q);
          repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 5))
              0: begin
                put_ch("\\");
                if ($urandom_range(9) == 0) put_ch(8'($urandom_range(255)));
                else put_ch(esc_chars[$urandom_range(5)]);
              end
              1: put_ch(8'($urandom_range(128, 255)));
              default: put_ch(8'($urandom_range(32, 126)));
            endcase
          end
          if ($urandom_range(7) != 0) put_ch(q);
        end
        9: begin
          put_ch("#");
          repeat ($urandom_range(0, 6)) put_ch(8'($urandom_range(11, 255)));
          break;
        end
        10: put_ch(8'($urandom_range(255)));
        default: put_eoi();
      endcase
      if ($urandom_range(4) < 3) put_ch($urandom_range(1) ? " " : "\t");
    end
    put_ch(8'd10);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL source_token_lexer");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      mode = M_IDLE;
      col = '0; tstart = '0; tcount = '0; kwin = '0; iacc = '0; facc = '0;
      fcnt = '0; seen_pt = 1'b0; dquote = 1'b0; pend_sym = '0;
    end else begin
      if (in_valid && in_ready) predict_tokens(in_data);
      if (!in_valid || in_ready) begin
        if (byte_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      cyc <= 0;
    end else begin
      out_item_t w;
      cyc <= cyc + 1;
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          $display("%0t unexpected token: expected none actual %h", $time, out_data);
          errors++;
        end else begin
          w = token_q.pop_front();
          check_field("token_kind", w.token_kind, out_data.token_kind);
          check_field("start_column", w.start_column, out_data.start_column);
          check_field("token_length", w.token_length, out_data.token_length);
          check_field("int_value", w.int_value, out_data.int_value);
          check_field("fraction_value", w.fraction_value, out_data.fraction_value);
          check_field("fraction_digits", w.fraction_digits, out_data.fraction_digits);
          check_field("char_value", w.char_value, out_data.char_value);
          check_field("error_code", w.error_code, out_data.error_code);
          check_field("is_last", w.is_last, out_data.is_last);
        end
      end
      if (cyc == 600) begin
        hold_cnt <= 400;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int target;
    errors = 0;
    send_idle = 13;
    recv_idle = 55;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    put_text("if 9.25<='a\\n'\n");
    put_ch(8'hFF);
    put_text("1.2.\n\"x\\q");
    put_eoi();

    for (int ph = 0; ph < 3; ph++) begin
      target = byte_q.size() + 25;
      if (ph == 0) begin
        put_text("1.");
        put_digits(1024);
        put_text(" x\n");
        target = byte_q.size() + 25;
      end
      while (byte_q.size() < target) put_line();
      while (byte_q.size() > 0 || in_valid) @(posedge clk);
      while (token_q.size() > 0) @(posedge clk);
      if (ph == 0) begin
        send_idle = 55;
        recv_idle = 13;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS source_token_lexer");
    end else begin
      $display("FAIL source_token_lexer");
    end
    $finish;
  end

endmodule
